@@ rtl/assert_macros.svh @@
// Assertion helper macros shared by the sound unit RTL.
// No dependencies; included by modules that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/fcsu_pkg.sv @@
// Shared types, constants and helper functions for the four channel sound unit.
// No dependencies.
package fcsu_pkg;

    localparam int unsigned DEF_CLOCK_HZ = 4194304;
    localparam int unsigned POS_W        = 21;
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
    localparam int unsigned LEN_CNT_W    = 9;
    localparam logic [14:0] LFSR_SEED    = 15'h7FFF;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic [15:0] ADDR_NR11 = 16'hFF11;
    localparam logic [15:0] ADDR_NR12 = 16'hFF12;
    localparam logic [15:0] ADDR_NR13 = 16'hFF13;
    localparam logic [15:0] ADDR_NR14 = 16'hFF14;
    localparam logic [15:0] ADDR_NR21 = 16'hFF16;
    localparam logic [15:0] ADDR_NR22 = 16'hFF17;
    localparam logic [15:0] ADDR_NR23 = 16'hFF18;
    localparam logic [15:0] ADDR_NR24 = 16'hFF19;
    localparam logic [15:0] ADDR_NR31 = 16'hFF1B;
    localparam logic [15:0] ADDR_NR32 = 16'hFF1C;
    localparam logic [15:0] ADDR_NR33 = 16'hFF1D;
    localparam logic [15:0] ADDR_NR34 = 16'hFF1E;
    localparam logic [15:0] ADDR_NR41 = 16'hFF20;
    localparam logic [15:0] ADDR_NR42 = 16'hFF21;
    localparam logic [15:0] ADDR_NR43 = 16'hFF22;
    localparam logic [15:0] ADDR_NR44 = 16'hFF23;
    localparam logic [15:0] ADDR_NR51 = 16'hFF25;
    localparam logic [15:0] ADDR_NR52 = 16'hFF26;
    localparam logic [11:0] ADDR_WAVE_HI = 12'hFF3;

    typedef enum logic [1:0] {
        ENV_NONE = 2'd0,
        ENV_UP   = 2'd1,
        ENV_DOWN = 2'd2
    } t_env_dir;

    // Per-channel operation decoded from one transaction.
    typedef struct packed {
        logic                 tick;
        logic                 len_wr;
        logic                 env_wr;
        logic                 freq_wr;
        logic                 trig_wr;
        logic [7:0]           data;
        logic [LEN_CNT_W-1:0] len_limit;
    } t_chan_op;

    typedef struct packed {
        logic [3:0] phase_bits;
        logic [3:0] square_one_volume;
        logic [3:0] square_two_volume;
        logic [3:0] wave_level;
        logic [3:0] noise_volume;
        logic [3:0] enabled_bits;
    } t_result;

    function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] p);
        return (p == POS_MAX) ? p : p + POS_W'(1);
    endfunction

    function automatic logic [5:0] duty_limit(input logic [1:0] d);
        logic [5:0] r;
        case (d)
            2'd0:    r = 6'd4;
            2'd1:    r = 6'd8;
            2'd2:    r = 6'd16;
            default: r = 6'd24;
        endcase
        return r;
    endfunction

    function automatic logic [6:0] noise_div(input logic [2:0] k);
        return (k == 3'd0) ? 7'd8 : {k, 4'b0000};
    endfunction

endpackage

@@ rtl/fcsu_length.sv @@
// Length counter for one channel: prescaler, count, limit and enable.
// Depends on fcsu_pkg.
module fcsu_length #(
    parameter int unsigned CLOCK_HZ = fcsu_pkg::DEF_CLOCK_HZ
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fcsu_pkg::t_chan_op i_op,
    output logic              o_live
);
    import fcsu_pkg::*;

    localparam int unsigned LEN_DIV = CLOCK_HZ / 256;
    localparam int unsigned LEN_W   = $clog2(LEN_DIV);

    logic [LEN_W-1:0]     r_pos,    n_pos;
    logic [LEN_CNT_W-1:0] r_count,  n_count;
    logic [LEN_CNT_W-1:0] r_limit,  n_limit;
    logic                 r_active, n_active;

    always_comb begin
        n_pos    = r_pos;
        n_count  = r_count;
        n_limit  = r_limit;
        n_active = r_active;
        if (i_op.tick) begin
            if (r_pos == LEN_W'(LEN_DIV - 1)) begin
                n_pos = '0;
                if (r_count < r_limit) n_count = r_count + LEN_CNT_W'(1);
            end else begin
                n_pos = r_pos + LEN_W'(1);
            end
        end
        if (i_op.len_wr) n_limit = i_op.len_limit;
        if (i_op.trig_wr) begin
            n_active = i_op.data[6];
            if (i_op.data[7]) begin
                n_pos   = '0;
                n_count = '0;
            end
        end
    end

    assign o_live = !(n_active && (n_count == n_limit));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_count  <= '0;
            r_limit  <= '0;
            r_active <= 1'b0;
        end else begin
            r_pos    <= n_pos;
            r_count  <= n_count;
            r_limit  <= n_limit;
            r_active <= n_active;
        end
    end

endmodule

@@ rtl/fcsu_envelope.sv @@
// Volume envelope for one square or noise channel, with the write quirks.
// Depends on fcsu_pkg.
module fcsu_envelope #(
    parameter int unsigned CLOCK_HZ = fcsu_pkg::DEF_CLOCK_HZ
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fcsu_pkg::t_chan_op i_op,
    output logic [3:0]        o_volume
);
    import fcsu_pkg::*;

    localparam int unsigned ENV_DIV = CLOCK_HZ / 64;
    localparam int unsigned ENV_W   = $clog2(ENV_DIV * 7 + 1);
    localparam logic [ENV_W-1:0] EnvDiv = ENV_W'(ENV_DIV);

    logic [ENV_W-1:0] r_pos,   n_pos;
    logic [3:0]       r_init,  n_init;
    logic [3:0]       r_vol,   n_vol;
    logic [2:0]       r_steps, n_steps;
    t_env_dir         r_dir,   n_dir;
    logic [ENV_W-1:0] thr;
    logic [ENV_W-1:0] pos_inc;

    assign thr     = EnvDiv * {{(ENV_W-3){1'b0}}, r_steps};
    assign pos_inc = r_pos + ENV_W'(1);

    always_comb begin
        n_pos   = r_pos;
        n_init  = r_init;
        n_vol   = r_vol;
        n_steps = r_steps;
        n_dir   = r_dir;
        // zero step count stops the envelope from stepping on ticks
        if (i_op.tick && (r_steps != 3'd0)) begin
            if (pos_inc >= thr) begin
                n_pos = pos_inc - thr;
                if (r_dir == ENV_DOWN && r_vol != 4'd0)      n_vol = r_vol - 4'd1;
                else if (r_dir == ENV_UP && r_vol != 4'd15) n_vol = r_vol + 4'd1;
            end else begin
                n_pos = pos_inc;
            end
        end
        if (i_op.env_wr) begin
            n_dir   = i_op.data[3] ? ENV_UP : ENV_DOWN;
            n_init  = i_op.data[7:4];
            n_steps = i_op.data[2:0];
            if (r_steps == 3'd0)  n_vol = r_vol + (i_op.data[3] ? 4'd1 : 4'd2);
            else if (n_dir != r_dir) n_vol = 4'd0 - r_vol;
        end
        if (i_op.trig_wr && i_op.data[7]) begin
            n_vol = r_init;
            n_pos = '0;
        end
    end

    assign o_volume = n_vol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_init  <= '0;
            r_vol   <= '0;
            r_steps <= '0;
            r_dir   <= ENV_NONE;
        end else begin
            r_pos   <= n_pos;
            r_init  <= n_init;
            r_vol   <= n_vol;
            r_steps <= n_steps;
            r_dir   <= n_dir;
        end
    end

endmodule

@@ rtl/fcsu_square.sv @@
// Square channel tone generator: period counter and 32-step duty pattern.
// Depends on fcsu_pkg.
module fcsu_square (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fcsu_pkg::t_chan_op i_op,
    output logic              o_phase
);
    import fcsu_pkg::*;

    logic [POS_W-1:0] r_pos,    n_pos;
    logic [10:0]      r_period, n_period;
    logic [1:0]       r_duty,   n_duty;
    logic [5:0]       r_step,   n_step;
    logic             r_phase,  n_phase;
    logic [POS_W-1:0] pos_inc;
    logic [11:0]      thr;
    logic [5:0]       cur_step;

    assign pos_inc  = sat_inc(r_pos);
    assign thr      = 12'd2048 - {1'b0, r_period};
    assign cur_step = (r_step >= 6'd32) ? 6'd0 : r_step;

    always_comb begin
        n_pos    = r_pos;
        n_period = r_period;
        n_duty   = r_duty;
        n_step   = r_step;
        n_phase  = r_phase;
        if (i_op.tick) begin
            if (pos_inc >= POS_W'(thr)) begin
                n_pos   = '0;
                n_phase = cur_step < duty_limit(r_duty);
                n_step  = cur_step + 6'd1;
            end else begin
                n_pos = pos_inc;
            end
        end
        if (i_op.len_wr)  n_duty = i_op.data[7:6];
        if (i_op.freq_wr) n_period[7:0] = i_op.data;
        if (i_op.trig_wr) begin
            n_period[10:8] = i_op.data[2:0];
            if (i_op.data[7]) n_step = '0;
        end
    end

    assign o_phase = n_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_period <= '0;
            r_duty   <= '0;
            r_step   <= '0;
            r_phase  <= 1'b0;
        end else begin
            r_pos    <= n_pos;
            r_period <= n_period;
            r_duty   <= n_duty;
            r_step   <= n_step;
            r_phase  <= n_phase;
        end
    end

endmodule

@@ rtl/fcsu_wave.sv @@
// Wave channel: 16-byte sample table, nibble fetch and volume shift.
// Depends on fcsu_pkg.
module fcsu_wave (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fcsu_pkg::t_chan_op i_op,
    input  logic              i_vol_wr,
    input  logic              i_tbl_wr,
    input  logic [3:0]        i_tbl_idx,
    output logic              o_phase,
    output logic [3:0]        o_level
);
    import fcsu_pkg::*;

    logic [7:0]       r_tbl [16];
    logic [POS_W-1:0] r_pos,    n_pos;
    logic [10:0]      r_period, n_period;
    logic [1:0]       r_code,   n_code;
    logic [3:0]       r_level,  n_level;
    logic [5:0]       r_step,   n_step;
    logic             r_phase,  n_phase;
    logic [POS_W-1:0] pos_inc;
    logic [12:0]      thr;
    logic [5:0]       cur_step;
    logic [7:0]       sbyte;
    logic [3:0]       nib;
    logic [3:0]       shifted;

    assign pos_inc  = sat_inc(r_pos);
    assign thr      = {13'd2048 - {2'b00, r_period}} << 1;
    assign cur_step = (r_step >= 6'd32) ? 6'd0 : r_step;
    assign sbyte    = r_tbl[cur_step[4:1]];
    assign nib      = cur_step[0] ? sbyte[7:4] : sbyte[3:0];

    always_comb begin
        case (r_code)
            2'd0:    shifted = 4'd0;
            2'd1:    shifted = nib;
            2'd2:    shifted = nib >> 1;
            default: shifted = nib >> 2;
        endcase
    end

    always_comb begin
        n_pos    = r_pos;
        n_period = r_period;
        n_code   = r_code;
        n_level  = r_level;
        n_step   = r_step;
        n_phase  = r_phase;
        if (i_op.tick) begin
            if (pos_inc >= POS_W'(thr)) begin
                n_pos   = '0;
                n_phase = 1'b1;
                n_level = shifted;
                n_step  = cur_step + 6'd1;
            end else begin
                n_pos = pos_inc;
            end
        end
        if (i_vol_wr)     n_code = i_op.data[6:5];
        if (i_op.freq_wr) n_period[7:0] = i_op.data;
        if (i_op.trig_wr) begin
            n_period[10:8] = i_op.data[2:0];
            if (i_op.data[7]) begin
                n_step  = '0;
                // level shows the raw volume code until the next fetch
                n_level = {2'b00, r_code};
            end
        end
    end

    assign o_phase = n_phase;
    assign o_level = n_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_period <= '0;
            r_code   <= '0;
            r_level  <= '0;
            r_step   <= '0;
            r_phase  <= 1'b0;
            for (int i = 0; i < 16; i++) r_tbl[i] <= '0;
        end else begin
            r_pos    <= n_pos;
            r_period <= n_period;
            r_code   <= n_code;
            r_level  <= n_level;
            r_step   <= n_step;
            r_phase  <= n_phase;
            if (i_tbl_wr) r_tbl[i_tbl_idx] <= i_op.data;
        end
    end

endmodule

@@ rtl/four_channel_sound_unit.sv @@
// Top level of the four channel sound unit: decode, noise channel, result buffer.
// Depends on fcsu_pkg, fcsu_length, fcsu_envelope, fcsu_square, fcsu_wave, assert_macros.svh.
// Four-channel sound unit. Each input transaction is either one clock tick
// (command 0) or a register write (command 1, address 0xFF10-0xFF3F decoded).
// Every transaction, tick or write, yields exactly one result transaction with
// the channel phases, envelope volumes, wave level and audible-channel bits as
// they stand after that transaction. All channel state updates in the cycle a
// transaction is accepted, so one transaction per cycle is sustained while
// o_stall is low; the result lands in an output register backed by a
// one-entry skid buffer, so o_stall only rises after the output side has
// stalled with two results held. CLOCK_HZ sets the length prescaler
// (CLOCK_HZ/256 ticks) and the envelope step (step count x CLOCK_HZ/64 ticks).
// Envelopes with a zero step count are frozen. Unused addresses are ignored.
module four_channel_sound_unit #(
    parameter int unsigned CLOCK_HZ = fcsu_pkg::DEF_CLOCK_HZ
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_command,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_phase_bits,
    output logic [3:0]  o_square_one_volume,
    output logic [3:0]  o_square_two_volume,
    output logic [3:0]  o_wave_level,
    output logic [3:0]  o_noise_volume,
    output logic [3:0]  o_enabled_bits
);
    import fcsu_pkg::*;
    `include "assert_macros.svh"

    logic     accept, tick_acc, wr_acc;
    t_chan_op op [4];
    logic     wave_vol_wr, tbl_wr, poly_wr, pan_wr, master_wr;
    logic [3:0] live;
    logic [3:0] phase;
    logic [3:0] vol0, vol1, vol3, wave_lvl;

    // handshake and decode
    assign accept   = i_valid && !o_stall;
    assign tick_acc = accept && (i_command == CMD_TICK);
    assign wr_acc   = accept && (i_command == CMD_WRITE);

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            op[c].tick      = tick_acc;
            op[c].len_wr    = 1'b0;
            op[c].env_wr    = 1'b0;
            op[c].freq_wr   = 1'b0;
            op[c].trig_wr   = 1'b0;
            op[c].data      = i_data;
            op[c].len_limit = LEN_CNT_W'(7'd64 - {1'b0, i_data[5:0]});
        end
        op[2].len_limit = LEN_CNT_W'(9'd256 - {1'b0, i_data});
        wave_vol_wr = 1'b0;
        poly_wr     = 1'b0;
        pan_wr      = 1'b0;
        master_wr   = 1'b0;
        tbl_wr      = wr_acc && (i_address[15:4] == ADDR_WAVE_HI);
        unique case (i_address)
            ADDR_NR11: op[0].len_wr  = wr_acc;
            ADDR_NR12: op[0].env_wr  = wr_acc;
            ADDR_NR13: op[0].freq_wr = wr_acc;
            ADDR_NR14: op[0].trig_wr = wr_acc;
            ADDR_NR21: op[1].len_wr  = wr_acc;
            ADDR_NR22: op[1].env_wr  = wr_acc;
            ADDR_NR23: op[1].freq_wr = wr_acc;
            ADDR_NR24: op[1].trig_wr = wr_acc;
            ADDR_NR31: op[2].len_wr  = wr_acc;
            ADDR_NR32: wave_vol_wr   = wr_acc;
            ADDR_NR33: op[2].freq_wr = wr_acc;
            ADDR_NR34: op[2].trig_wr = wr_acc;
            ADDR_NR41: op[3].len_wr  = wr_acc;
            ADDR_NR42: op[3].env_wr  = wr_acc;
            ADDR_NR43: poly_wr       = wr_acc;
            ADDR_NR44: op[3].trig_wr = wr_acc;
            ADDR_NR51: pan_wr        = wr_acc;
            ADDR_NR52: master_wr     = wr_acc;
            default: ;
        endcase
    end

    // channel blocks
    for (genvar c = 0; c < 4; c++) begin : g_len
        fcsu_length #(.CLOCK_HZ(CLOCK_HZ)) u_len (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_op(op[c]), .o_live(live[c])
        );
    end

    fcsu_envelope #(.CLOCK_HZ(CLOCK_HZ)) u_env0 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_op(op[0]), .o_volume(vol0)
    );
    fcsu_envelope #(.CLOCK_HZ(CLOCK_HZ)) u_env1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_op(op[1]), .o_volume(vol1)
    );
    fcsu_envelope #(.CLOCK_HZ(CLOCK_HZ)) u_env3 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_op(op[3]), .o_volume(vol3)
    );

    fcsu_square u_sq0 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_op(op[0]), .o_phase(phase[0])
    );
    fcsu_square u_sq1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_op(op[1]), .o_phase(phase[1])
    );

    fcsu_wave u_wave (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_op     (op[2]),
        .i_vol_wr (wave_vol_wr),
        .i_tbl_wr (tbl_wr),
        .i_tbl_idx(i_address[3:0]),
        .o_phase  (phase[2]),
        .o_level  (wave_lvl)
    );

    // noise channel: period counter and LFSR
    logic [POS_W-1:0] r_nz_pos,    n_nz_pos;
    logic [POS_W-1:0] r_nz_period, n_nz_period;
    logic             r_nz_short,  n_nz_short;
    logic [14:0]      r_lfsr,      n_lfsr;
    logic             r_nz_phase,  n_nz_phase;
    logic [POS_W-1:0] nz_inc;
    logic             nz_fb;
    logic [14:0]      lfsr_sh;

    assign nz_inc  = sat_inc(r_nz_pos);
    assign nz_fb   = r_lfsr[0] ^ r_lfsr[1];
    assign lfsr_sh = {nz_fb, r_lfsr[14:1]};

    always_comb begin
        n_nz_pos    = r_nz_pos;
        n_nz_period = r_nz_period;
        n_nz_short  = r_nz_short;
        n_lfsr      = r_lfsr;
        n_nz_phase  = r_nz_phase;
        if (tick_acc) begin
            // a zero period (shift code 14 or 15) never fires
            if ((r_nz_period != '0) && (nz_inc >= r_nz_period)) begin
                n_nz_pos   = '0;
                n_nz_phase = ~r_lfsr[0];
                n_lfsr     = lfsr_sh;
                if (r_nz_short) n_lfsr[6] = nz_fb;
            end else begin
                n_nz_pos = nz_inc;
            end
        end
        if (poly_wr) begin
            n_nz_short = i_data[3];
            if (i_data[7:4] < 4'd14) begin
                n_nz_period = POS_W'(noise_div(i_data[2:0])) << ({1'b0, i_data[7:4]} + 5'd1);
            end else begin
                n_nz_period = '0;
            end
        end
        if (op[3].trig_wr && i_data[7]) n_lfsr = LFSR_SEED;
    end

    assign phase[3] = n_nz_phase;

    // pan and master control
    logic [7:0] r_pan,    n_pan;
    logic [7:0] r_master, n_master;

    assign n_pan    = pan_wr    ? i_data : r_pan;
    assign n_master = master_wr ? i_data : r_master;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nz_pos    <= '0;
            r_nz_period <= '0;
            r_nz_short  <= 1'b0;
            r_lfsr      <= LFSR_SEED;
            r_nz_phase  <= 1'b0;
            r_pan       <= '0;
            r_master    <= '0;
        end else begin
            r_nz_pos    <= n_nz_pos;
            r_nz_period <= n_nz_period;
            r_nz_short  <= n_nz_short;
            r_lfsr      <= n_lfsr;
            r_nz_phase  <= n_nz_phase;
            r_pan       <= n_pan;
            r_master    <= n_master;
        end
    end

    // result assembly from post-transaction state
    t_result res;
    always_comb begin
        res.phase_bits        = phase;
        res.square_one_volume = vol0;
        res.square_two_volume = vol1;
        res.wave_level        = wave_lvl;
        res.noise_volume      = vol3;
        res.enabled_bits      = live & (n_pan[3:0] | n_pan[7:4]) & {4{n_master[7]}};
    end

    // output register plus one-entry skid buffer
    t_result r_out, r_skid;
    logic    r_out_valid, r_skid_valid;
    logic    out_pop;

    assign out_pop = r_out_valid && !i_stall;
    assign o_stall = r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_pop) r_skid_valid <= 1'b0;
        end else if (accept) begin
            if (!r_out_valid || out_pop) r_out_valid  <= 1'b1;
            else                         r_skid_valid <= 1'b1;
        end else if (out_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_pop) r_out <= r_skid;
        end else if (accept) begin
            if (!r_out_valid || out_pop) r_out  <= res;
            else                         r_skid <= res;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_phase_bits        = r_out.phase_bits;
    assign o_square_one_volume = r_out.square_one_volume;
    assign o_square_two_volume = r_out.square_two_volume;
    assign o_wave_level        = r_out.wave_level;
    assign o_noise_volume      = r_out.noise_volume;
    assign o_enabled_bits      = r_out.enabled_bits;

    `ASSERT_IMPL(a_skid_needs_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `ASSERT_NEXT(a_accept_lands, i_clk, i_rst_n, accept, r_out_valid)
    `ASSERT_NEXT(a_full_stall_skids, i_clk, i_rst_n,
                 accept && r_out_valid && i_stall, r_skid_valid)

endmodule
